FILE: design/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define SUA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sua check failed");

// Next-cycle implication, also checked during reset.
`define SUA_ASSERT_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("sua check failed");

`endif

FILE: design/sua_pkg.sv
// Package: constants, codes and link types of the slot allocator.
package sua_pkg;

   localparam int MAX_SLOTS   = 8;
   localparam int METER_BITS  = 32;
   localparam int SLOT_BITS   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CNT_BITS    = $clog2(MAX_SLOTS + 1);
   localparam int CFG_BITS    = 4;
   localparam int CMD_BITS    = 2;
   localparam int ID_BITS     = 4;
   localparam int STATUS_BITS = 3;
   localparam int GIVEN_BITS  = 3;
   localparam int VALUE_BITS  = 32;
   localparam int CMP_BITS    = (CNT_BITS > ID_BITS) ? CNT_BITS :
                                ((CFG_BITS > ID_BITS) ? CFG_BITS : ID_BITS);
   localparam logic [CFG_BITS-1:0]   CFG_RESET = CFG_BITS'(MAX_SLOTS);
   localparam logic [METER_BITS-1:0] METER_MAX = {METER_BITS{1'b1}};
   localparam logic [METER_BITS-1:0] METER_ONE = METER_BITS'(1);

   typedef enum logic [CMD_BITS-1:0] {
      CMD_ALLOC   = 2'd0,
      CMD_RELEASE = 2'd1,
      CMD_TICK    = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_ALLOCATED = 3'd0,
      ST_FULL      = 3'd1,
      ST_RELEASED  = 3'd2,
      ST_INVALID   = 3'd3,
      ST_EMPTY     = 3'd4,
      ST_TICK      = 3'd5
   } status_type;

   // Broadcast to every cell for the transaction being executed.
   typedef struct packed {
      logic                fire;
      logic [CMD_BITS-1:0] cmd;
      logic [CMP_BITS-1:0] sel;
      logic                sel_ok;
   } ctrl_type;

   // Passed from cell to cell, lowest slot first.
   typedef struct packed {
      logic                  taken;
      logic [SLOT_BITS-1:0]  given;
      logic                  found;
      logic [METER_BITS-1:0] meter;
   } link_type;

endpackage

FILE: design/sua_cell.sv
// One slot cell: occupancy bit and usage meter, plus its stage of the link chain.
module sua_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [sua_pkg::SLOT_BITS-1:0]  cell_idx,
   input  logic                           managed,
   input  sua_pkg::ctrl_type              ctrl,
   input  sua_pkg::link_type              link_in,
   output sua_pkg::link_type              link_out
);

   logic                           occ_ff, occ_in;
   logic [sua_pkg::METER_BITS-1:0] meter_ff, meter_in;
   logic                           sel_hit, claim, drop, bump;

   assign sel_hit = ctrl.sel_ok && (ctrl.sel == sua_pkg::CMP_BITS'(cell_idx));

   always_comb begin
      claim = 1'b0;
      drop  = 1'b0;
      bump  = 1'b0;
      unique case (ctrl.cmd)
         sua_pkg::CMD_ALLOC:   claim = managed && !occ_ff && !link_in.taken;
         sua_pkg::CMD_RELEASE: drop  = sel_hit && occ_ff;
         sua_pkg::CMD_TICK:    bump  = managed && occ_ff && (meter_ff != sua_pkg::METER_MAX);
         default:              ;
      endcase
   end

   always_comb begin
      occ_in   = occ_ff;
      meter_in = meter_ff;
      if (ctrl.fire) begin
         if (claim) begin
            occ_in   = 1'b1;
            meter_in = sua_pkg::METER_ONE;
         end else if (drop) begin
            occ_in   = 1'b0;
            meter_in = '0;
         end else if (bump) begin
            meter_in = meter_ff + sua_pkg::METER_ONE;
         end
      end
   end

   always_comb begin
      link_out       = link_in;
      link_out.taken = link_in.taken | claim;
      if (claim) begin
         link_out.given = cell_idx;
      end
      if (sel_hit && occ_ff) begin
         link_out.found = 1'b1;
         link_out.meter = meter_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         meter_ff <= '0;
      end else begin
         meter_ff <= meter_in;
      end
   end

endmodule

FILE: design/slot_allocator_with_usage_meters.sv
// Top level: slot allocator built from a chain of slot cells with a result register.
// Usage:
//   req_ channel carries one transaction: req_command (0 allocate, 1 release,
//   2 tick) and req_slot_number (used by release only).
//   rsp_ channel returns exactly one transaction per request: rsp_status,
//   rsp_slot_given and rsp_meter_value.
//   csr_write_enable / csr_write_data set the managed slot count (4 bits);
//   values above the slot total act as the total. Write only while idle.
// Timing:
//   Each request is executed in the cycle it is accepted; its result is
//   valid on the rsp_ ports in the next cycle.
//   Throughput is one transaction per cycle while req_stall is low: the
//   first-free search and meter readout ripple combinationally through all cells.
// Stall:
//   The result register holds while it is full and rsp_stall is high; req_stall is raised
//   only when that register is full and stalled, and it reloads in the same
//   cycle it is drained.
// Reset:
//   Synchronous, active high. All slots free, count back to the slot total,
//   no result pending. No clearing pass is needed.
module slot_allocator_with_usage_meters (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [sua_pkg::CMD_BITS-1:0]      req_command,
   input  logic [sua_pkg::ID_BITS-1:0]       req_slot_number,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [sua_pkg::STATUS_BITS-1:0]   rsp_status,
   output logic [sua_pkg::GIVEN_BITS-1:0]    rsp_slot_given,
   output logic [sua_pkg::VALUE_BITS-1:0]    rsp_meter_value,
   input  logic                              csr_write_enable,
   input  logic [sua_pkg::CFG_BITS-1:0]      csr_write_data
);

   logic [sua_pkg::CFG_BITS-1:0]    cfg_ff;
   logic [sua_pkg::CMP_BITS-1:0]    active_cnt, cfg_ext, sel_ext;
   logic                            accept;
   sua_pkg::ctrl_type               ctrl;
   sua_pkg::link_type               link [0:sua_pkg::MAX_SLOTS];
   logic [sua_pkg::MAX_SLOTS-1:0]   managed;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [sua_pkg::STATUS_BITS-1:0] status_ff, status_in;
   logic [sua_pkg::GIVEN_BITS-1:0]  given_ff, given_in;
   logic [sua_pkg::VALUE_BITS-1:0]  meter_ff, meter_in;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign cfg_ext    = sua_pkg::CMP_BITS'(cfg_ff);
   assign active_cnt = (cfg_ext > sua_pkg::CMP_BITS'(sua_pkg::MAX_SLOTS)) ?
                       sua_pkg::CMP_BITS'(sua_pkg::MAX_SLOTS) : cfg_ext;
   assign sel_ext    = sua_pkg::CMP_BITS'(req_slot_number);

   assign ctrl.fire   = accept;
   assign ctrl.cmd    = req_command;
   assign ctrl.sel    = sel_ext;
   assign ctrl.sel_ok = sel_ext < active_cnt;

   assign link[0] = '0;

   for (genvar i = 0; i < sua_pkg::MAX_SLOTS; i++) begin : g_cell
      assign managed[i] = sua_pkg::CMP_BITS'(i) < active_cnt;
      sua_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (sua_pkg::SLOT_BITS'(i)),
         .managed  (managed[i]),
         .ctrl     (ctrl),
         .link_in  (link[i]),
         .link_out (link[i+1])
      );
   end

   always_comb begin
      status_in = sua_pkg::ST_INVALID;
      given_in  = '0;
      meter_in  = '0;
      unique case (req_command)
         sua_pkg::CMD_ALLOC: begin
            if (link[sua_pkg::MAX_SLOTS].taken) begin
               status_in = sua_pkg::ST_ALLOCATED;
               given_in  = sua_pkg::GIVEN_BITS'(link[sua_pkg::MAX_SLOTS].given);
            end else begin
               status_in = sua_pkg::ST_FULL;
            end
         end
         sua_pkg::CMD_RELEASE: begin
            if (!ctrl.sel_ok) begin
               status_in = sua_pkg::ST_INVALID;
            end else if (link[sua_pkg::MAX_SLOTS].found) begin
               status_in = sua_pkg::ST_RELEASED;
               meter_in  = sua_pkg::VALUE_BITS'(link[sua_pkg::MAX_SLOTS].meter);
            end else begin
               status_in = sua_pkg::ST_EMPTY;
            end
         end
         sua_pkg::CMD_TICK: status_in = sua_pkg::ST_TICK;
         default:           status_in = sua_pkg::ST_INVALID;
      endcase
   end

   assign rsp_valid_in = accept || req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= sua_pkg::CFG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            cfg_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         given_ff  <= given_in;
         meter_ff  <= meter_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_slot_given  = given_ff;
   assign rsp_meter_value = meter_ff;

endmodule

FILE: design/sua_checker.sv
// Port-level checker for the slot allocator, bound to the top level.
`include "assert_macros.svh"

module sua_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [sua_pkg::STATUS_BITS-1:0]   rsp_status,
   input logic [sua_pkg::GIVEN_BITS-1:0]    rsp_slot_given,
   input logic [sua_pkg::VALUE_BITS-1:0]    rsp_meter_value
);

   `SUA_ASSERT_NEXT(a_reset_empty, clock, reset, !rsp_valid)
   `SUA_ASSERT_NOW(a_status_known, clock, reset, rsp_valid, rsp_status <= sua_pkg::ST_TICK)
   `SUA_ASSERT_NOW(a_meter_release_only, clock, reset, rsp_valid && (rsp_status != sua_pkg::ST_RELEASED), rsp_meter_value == '0)
   `SUA_ASSERT_NOW(a_given_alloc_only, clock, reset, rsp_valid && (rsp_status != sua_pkg::ST_ALLOCATED), rsp_slot_given == '0)
   `SUA_ASSERT_NEXT(a_stall_hold, clock, !reset && rsp_valid && rsp_stall, reset || (rsp_valid && $stable(rsp_status) && $stable(rsp_meter_value)))

endmodule

bind slot_allocator_with_usage_meters sua_checker u_sua_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_slot_given  (rsp_slot_given),
   .rsp_meter_value (rsp_meter_value)
);

FILE: dv/tb.sv
// Testbench for the slot allocator: directed and random requests checked against a predictor.
module tb;

   localparam logic [sua_pkg::CMD_BITS-1:0] CMD_UNUSED = 2'd3;

   typedef struct {
      logic [sua_pkg::CMD_BITS-1:0] command;
      logic [sua_pkg::ID_BITS-1:0]  slot;
   } slot_request_type;

   typedef struct {
      sua_pkg::status_type            status;
      logic [sua_pkg::GIVEN_BITS-1:0] given;
      logic [sua_pkg::VALUE_BITS-1:0] meter;
   } slot_result_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [sua_pkg::CMD_BITS-1:0]    req_command = '0;
   logic [sua_pkg::ID_BITS-1:0]     req_slot_number = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [sua_pkg::STATUS_BITS-1:0] rsp_status;
   logic [sua_pkg::GIVEN_BITS-1:0]  rsp_slot_given;
   logic [sua_pkg::VALUE_BITS-1:0]  rsp_meter_value;
   logic                            csr_write_enable = 1'b0;
   logic [sua_pkg::CFG_BITS-1:0]    csr_write_data = '0;

   // predictor state
   logic [sua_pkg::CFG_BITS-1:0]    slot_count = sua_pkg::CFG_RESET;
   logic                            slot_busy [sua_pkg::MAX_SLOTS];
   logic [sua_pkg::METER_BITS-1:0]  slot_meter [sua_pkg::MAX_SLOTS];

   slot_request_type                pending_requests [$];
   slot_result_type                 results_due [$];
   slot_request_type                next_request;
   slot_result_type                 oldest_due;

   int unsigned                     sender_idle_pct = 0;
   int unsigned                     stall_pct = 0;
   int unsigned                     mismatches = 0;
   int unsigned                     requests_taken = 0;
   int unsigned                     results_checked = 0;
   int unsigned                     settings_used = 0;
   int unsigned                     status_seen [6];
   logic [sua_pkg::VALUE_BITS-1:0]  largest_meter = '0;
   logic [sua_pkg::CFG_BITS-1:0]    count_steps [13] = '{4'd8, 4'd1, 4'd4, 4'd15, 4'd0, 4'd6,
                                                         4'd2, 4'd9, 4'd7, 4'd5, 4'd3, 4'd8,
                                                         4'd12};

   slot_allocator_with_usage_meters DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_slot_number  (req_slot_number),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_slot_given   (rsp_slot_given),
      .rsp_meter_value  (rsp_meter_value),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic slot_result_type predict_request(
         logic [sua_pkg::CMD_BITS-1:0] command,
         logic [sua_pkg::ID_BITS-1:0]  slot);
      slot_result_type res;
      int              active;
      active = (int'(slot_count) > sua_pkg::MAX_SLOTS) ? sua_pkg::MAX_SLOTS : int'(slot_count);
      res.status = sua_pkg::ST_INVALID;
      res.given  = '0;
      res.meter  = '0;
      case (command)
         sua_pkg::CMD_ALLOC: begin
            res.status = sua_pkg::ST_FULL;
            for (int i = 0; i < active; i++) begin
               if (!slot_busy[i] && res.status == sua_pkg::ST_FULL) begin
                  slot_busy[i]  = 1'b1;
                  slot_meter[i] = sua_pkg::METER_ONE;
                  res.status    = sua_pkg::ST_ALLOCATED;
                  res.given     = sua_pkg::GIVEN_BITS'(i);
               end
            end
         end
         sua_pkg::CMD_RELEASE: begin
            if (int'(slot) >= active) begin
               res.status = sua_pkg::ST_INVALID;
            end else if (!slot_busy[slot[sua_pkg::SLOT_BITS-1:0]]) begin
               res.status = sua_pkg::ST_EMPTY;
            end else begin
               res.status = sua_pkg::ST_RELEASED;
               res.meter  = slot_meter[slot[sua_pkg::SLOT_BITS-1:0]];
               slot_busy[slot[sua_pkg::SLOT_BITS-1:0]]  = 1'b0;
               slot_meter[slot[sua_pkg::SLOT_BITS-1:0]] = '0;
            end
         end
         sua_pkg::CMD_TICK: begin
            for (int i = 0; i < active; i++) begin
               if (slot_busy[i] && slot_meter[i] != sua_pkg::METER_MAX) begin
                  slot_meter[i] = slot_meter[i] + sua_pkg::METER_ONE;
               end
            end
            res.status = sua_pkg::ST_TICK;
         end
         default: begin
            res.status = sua_pkg::ST_INVALID;
         end
      endcase
      return res;
   endfunction

   function automatic void queue_request(logic [sua_pkg::CMD_BITS-1:0] command,
                                         logic [sua_pkg::ID_BITS-1:0]  slot);
      slot_request_type r;
      r.command = command;
      r.slot    = slot;
      pending_requests.push_back(r);
   endfunction

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || results_due.size() != 0);
   endtask

   task automatic set_slot_count(logic [sua_pkg::CFG_BITS-1:0] value);
      wait_idle();
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      slot_count = value;
      settings_used++;
      @(negedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            results_due.push_back(predict_request(req_command, req_slot_number));
            requests_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               next_request = pending_requests.pop_front();
               req_valid       <= 1'b1;
               req_command     <= next_request.command;
               req_slot_number <= next_request.slot;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (results_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("unexpected transaction: status %0d slot %0d meter %0d",
                           rsp_status, rsp_slot_given, rsp_meter_value);
               end
            end else begin
               oldest_due = results_due.pop_front();
               results_checked++;
               status_seen[oldest_due.status]++;
               if (oldest_due.meter > largest_meter) begin
                  largest_meter = oldest_due.meter;
               end
               if (rsp_status !== oldest_due.status || rsp_slot_given !== oldest_due.given ||
                   rsp_meter_value !== oldest_due.meter) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch: expected status %0d slot %0d meter %0d, got %0d %0d %0d",
                              oldest_due.status, oldest_due.given, oldest_due.meter,
                              rsp_status, rsp_slot_given, rsp_meter_value);
                  end
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   initial begin
      int                          active;
      int unsigned                 pick;
      logic [sua_pkg::ID_BITS-1:0] slot;
      for (int i = 0; i < sua_pkg::MAX_SLOTS; i++) begin
         slot_busy[i]  = 1'b0;
         slot_meter[i] = '0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // fill every slot, overflow, age, release and reuse
      for (int i = 0; i <= sua_pkg::MAX_SLOTS; i++) queue_request(sua_pkg::CMD_ALLOC, 4'd0);
      queue_request(sua_pkg::CMD_TICK, 4'd0);
      queue_request(sua_pkg::CMD_TICK, 4'd0);
      queue_request(sua_pkg::CMD_RELEASE, 4'd3);
      queue_request(sua_pkg::CMD_RELEASE, 4'd3);
      queue_request(sua_pkg::CMD_RELEASE, 4'd8);
      queue_request(sua_pkg::CMD_RELEASE, 4'd15);
      queue_request(CMD_UNUSED, 4'd10);
      queue_request(sua_pkg::CMD_ALLOC, 4'd0);
      queue_request(sua_pkg::CMD_RELEASE, 4'd0);
      queue_request(sua_pkg::CMD_RELEASE, 4'd7);
      queue_request(sua_pkg::CMD_TICK, 4'd0);

      // no managed slots
      set_slot_count(4'd0);
      queue_request(sua_pkg::CMD_ALLOC, 4'd0);
      queue_request(sua_pkg::CMD_RELEASE, 4'd0);
      queue_request(sua_pkg::CMD_TICK, 4'd0);

      // lowered count: upper slots frozen
      set_slot_count(4'd3);
      queue_request(sua_pkg::CMD_ALLOC, 4'd0);
      queue_request(sua_pkg::CMD_ALLOC, 4'd0);
      queue_request(sua_pkg::CMD_TICK, 4'd0);
      queue_request(sua_pkg::CMD_RELEASE, 4'd5);
      queue_request(sua_pkg::CMD_RELEASE, 4'd2);

      // count above the slot total
      set_slot_count(4'd15);
      queue_request(sua_pkg::CMD_TICK, 4'd0);
      queue_request(sua_pkg::CMD_RELEASE, 4'd5);

      foreach (count_steps[p]) begin
         set_slot_count(count_steps[p]);
         sender_idle_pct = (p % 4 == 1) ? 59 : (p % 4 == 3) ? 19 : 0;
         stall_pct       = (p % 4 == 2) ? 59 : (p % 4 == 3) ? 19 : 0;
         active = (int'(slot_count) > sua_pkg::MAX_SLOTS) ? sua_pkg::MAX_SLOTS
                                                          : int'(slot_count);
         repeat (105) begin
            pick = $urandom_range(99);
            slot = sua_pkg::ID_BITS'($urandom_range(15));
            if (active != 0 && $urandom_range(9) < 8) begin
               slot = sua_pkg::ID_BITS'($urandom_range(active - 1));
            end
            if (pick < 35) queue_request(sua_pkg::CMD_ALLOC, slot);
            else if (pick < 65) queue_request(sua_pkg::CMD_RELEASE, slot);
            else if (pick < 95) queue_request(sua_pkg::CMD_TICK, slot);
            else queue_request(CMD_UNUSED, slot);
         end
      end

      wait_idle();
      repeat (5) @(posedge clock);
      $display("checked %0d of %0d transactions over %0d slot-count settings, four idle modes",
               results_checked, requests_taken, settings_used);
      $display("alloc %0d full %0d released %0d (max meter %0d) invalid %0d empty %0d tick %0d",
               status_seen[sua_pkg::ST_ALLOCATED], status_seen[sua_pkg::ST_FULL],
               status_seen[sua_pkg::ST_RELEASED], largest_meter,
               status_seen[sua_pkg::ST_INVALID], status_seen[sua_pkg::ST_EMPTY],
               status_seen[sua_pkg::ST_TICK]);
      if (mismatches == 0 && results_due.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+design
design/sua_pkg.sv
design/sua_cell.sv
design/slot_allocator_with_usage_meters.sv
design/sua_checker.sv
dv/tb.sv
